### hw/rtl/baro_pressure_temp_compensation_core_defines.svh
// Assertion macros shared by the compensation core and its divider.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_CORE_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, inactive while arst_n is low.
`define BPC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("bpc assertion failed");
// Next-cycle implication, sampled on clk, inactive while arst_n is low.
`define BPC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("bpc assertion failed");
`else
`define BPC_ASSERT_IMP(lbl, ante, cons)
`define BPC_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/bpc_pkg.sv
// Types and constants of the barometric compensation core.
package bpc_pkg;

	// Register indexes on the write port.
	localparam logic [1:0] REG_OVERSAMPLING = 2'd0;
	localparam logic [1:0] REG_CAL_WORD_A   = 2'd1;
	localparam logic [1:0] REG_CAL_WORD_B   = 2'd2;
	localparam logic [1:0] REG_CAL_WORD_C   = 2'd3;

	localparam int RAW_T_W  = 16;
	localparam int RAW_P_W  = 19;
	localparam int TEMP_W   = 16;
	localparam int PRESS_W  = 18;
	localparam int CFG_W    = 64;
	localparam int CFG_IDX_W = 2;

	// Datasheet constants.
	localparam int T_OFFSET  = 4000;
	localparam int C_X1      = 3038;
	localparam int C_X2      = -7357;
	localparam int C_SUM     = 3791;
	localparam int P_SCALE   = 50000;
	localparam int B4_BIAS   = 32768;
	localparam int TEMP_MAX  = 32767;
	localparam int TEMP_MIN  = -32768;
	localparam int PRESS_MAX = 262143;

	// Divider widths.
	localparam int DIV1_NUM_W = 27;
	localparam int DIV1_DEN_W = 18;
	localparam int DIV2_NUM_W = 32;
	localparam int DIV2_DEN_W = 17;

	// Data carried alongside the temperature division.
	typedef struct packed {
		logic               dz;
		logic               neg;
		logic signed [16:0] x1;
		logic [RAW_P_W-1:0] up;
	} div1_side_t;

	// Data carried alongside the pressure division.
	typedef struct packed {
		logic                     err;
		logic                     big;
		logic signed [TEMP_W-1:0] temp;
	} div2_side_t;

endpackage

### hw/rtl/bpc_sample_if.sv
// Input channel: one raw temperature and pressure reading per item.
interface bpc_sample_if;
	logic                             valid;
	logic                             ready;
	logic [bpc_pkg::RAW_T_W-1:0]      raw_temperature;
	logic [bpc_pkg::RAW_P_W-1:0]      raw_pressure;

	modport source (output valid, output raw_temperature, output raw_pressure, input ready);
	modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

### hw/rtl/bpc_result_if.sv
// Output channel: one compensated result per item.
interface bpc_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [bpc_pkg::TEMP_W-1:0]  temperature;
	logic [bpc_pkg::PRESS_W-1:0]        pressure;
	logic                               math_error;

	modport source (output valid, output temperature, output pressure, output math_error,
		input ready);
	modport sink (input valid, input temperature, input pressure, input math_error,
		output ready);
endinterface

### hw/rtl/bpc_div_pipe.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
`include "baro_pressure_temp_compensation_core_defines.svh"

module bpc_div_pipe #(
	parameter int NUM_W  = 32,
	parameter int DEN_W  = 17,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side,
	output logic              out_valid,
	output logic [NUM_W-1:0]  quot,
	output logic [SIDE_W-1:0] side_out
);

	// Stage 0 holds the operands; stage k holds k quotient bits.
	logic              vld_s  [NUM_W+1];
	logic [NUM_W-1:0]  num_s  [NUM_W+1];
	logic [DEN_W-1:0]  rem_s  [NUM_W+1];
	logic [DEN_W-1:0]  den_s  [NUM_W+1];
	logic [SIDE_W-1:0] side_s [NUM_W+1];

	// Valid bits move with the data whenever the pipeline advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NUM_W; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i <= NUM_W; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// Operand capture.
	always_ff @(posedge clk) begin
		if (en) begin
			num_s[0]  <= num;
			rem_s[0]  <= '0;
			den_s[0]  <= den;
			side_s[0] <= side;
		end
	end

	// One trial subtraction per stage; the numerator shifts out as quotient bits shift in.
	for (genvar k = 0; k < NUM_W; k++) begin : g_step
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;

		assign trial = {rem_s[k], num_s[k][NUM_W-1]};
		assign diff  = trial - {1'b0, den_s[k]};
		assign ge    = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				num_s[k+1]  <= {num_s[k][NUM_W-2:0], ge};
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[NUM_W];
	assign quot      = num_s[NUM_W];
	assign side_out  = side_s[NUM_W];

	`BPC_ASSERT_NXT(a_div_shift, en, vld_s[NUM_W] == $past(vld_s[NUM_W-1]))
	`BPC_ASSERT_NXT(a_div_hold, !en, vld_s[NUM_W] == $past(vld_s[NUM_W]))
	`BPC_ASSERT_IMP(a_div_rem, vld_s[NUM_W] && den_s[NUM_W] != '0, rem_s[NUM_W] < den_s[NUM_W])

endmodule

### hw/rtl/baro_pressure_temp_compensation_core.sv
// Throughput: one item per cycle while the output is not stalled; the two dividers retire one quotient bit per stage.
// The pressure divider's 33 stages and the temperature divider's 28 set most of the latency.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (arst_n low) clears all valid bits, sets oversampling to 3 and calibration to 0.
`include "baro_pressure_temp_compensation_core_defines.svh"

module baro_pressure_temp_compensation_core (
	input  logic                              clk,
	input  logic                              arst_n,
	bpc_sample_if.sink                        sample,
	bpc_result_if.source                      result,
	input  logic                              wr_en,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [bpc_pkg::CFG_W-1:0]         wr_data
);

	// Configuration registers.
	logic [1:0]  oss_q;
	logic [63:0] cal_a_q;
	logic [63:0] cal_b_q;
	logic [31:0] cal_c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oss_q   <= 2'd3;
			cal_a_q <= '0;
			cal_b_q <= '0;
			cal_c_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				bpc_pkg::REG_OVERSAMPLING: oss_q   <= wr_data[1:0];
				bpc_pkg::REG_CAL_WORD_A:   cal_a_q <= wr_data;
				bpc_pkg::REG_CAL_WORD_B:   cal_b_q <= wr_data;
				bpc_pkg::REG_CAL_WORD_C:   cal_c_q <= wr_data[31:0];
				default: ;
			endcase
		end
	end

	// Calibration coefficients.
	logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic [15:0]        ac4, ac5, ac6;

	assign ac1 = cal_a_q[15:0];
	assign ac2 = cal_a_q[31:16];
	assign ac3 = cal_a_q[47:32];
	assign ac4 = cal_a_q[63:48];
	assign ac5 = cal_b_q[15:0];
	assign ac6 = cal_b_q[31:16];
	assign b1  = cal_b_q[47:32];
	assign b2  = cal_b_q[63:48];
	assign mc  = cal_c_q[15:0];
	assign md  = cal_c_q[31:16];

	// The whole pipeline advances unless the output item is held.
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic v_s10, v_s11, v_s12, v_s13;
	logic div1_vld, div2_vld;

	assign en           = !v_s13 || result.ready;
	assign sample.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (en) begin
			v_s1  <= sample.valid;
			v_s2  <= v_s1;
			v_s3  <= div1_vld;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= div2_vld;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	// Stage 1: (ut - ac6) * ac5.
	logic signed [16:0] t_diff;
	logic signed [33:0] t_prod;
	logic [31:0]        tprod_s1;
	logic [18:0]        up_s1;

	assign t_diff = $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, ac6});
	assign t_prod = t_diff * $signed({1'b0, ac5});

	always_ff @(posedge clk) begin
		if (en) begin
			tprod_s1 <= t_prod[31:0];
			up_s1    <= sample.raw_pressure;
		end
	end

	// Stage 2: x1 and the divisor x1 + md.
	logic signed [16:0] x1_t;
	logic signed [17:0] den_c;
	logic signed [16:0] x1_s2;
	logic signed [17:0] den_s2;
	logic [18:0]        up_s2;

	assign x1_t  = tprod_s1[31:15];
	assign den_c = x1_t + md;

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s2  <= x1_t;
			den_s2 <= den_c;
			up_s2  <= up_s1;
		end
	end

	// Temperature division on magnitudes, sign restored afterwards.
	logic [15:0]                          mc_abs;
	logic [bpc_pkg::DIV1_DEN_W-1:0]       den_abs;
	bpc_pkg::div1_side_t                  div1_side_i, div1_side_o;
	logic [bpc_pkg::DIV1_NUM_W-1:0]       q1;

	assign mc_abs  = cal_c_q[15] ? (16'd0 - cal_c_q[15:0]) : cal_c_q[15:0];
	assign den_abs = den_s2[17] ? (18'd0 - den_s2) : den_s2;

	always_comb begin
		div1_side_i.dz  = den_s2 == '0;
		div1_side_i.neg = cal_c_q[15] ^ den_s2[17];
		div1_side_i.x1  = x1_s2;
		div1_side_i.up  = up_s2;
	end

	bpc_div_pipe #(
		.NUM_W  (bpc_pkg::DIV1_NUM_W),
		.DEN_W  (bpc_pkg::DIV1_DEN_W),
		.SIDE_W ($bits(bpc_pkg::div1_side_t))
	) u_div_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.num       ({mc_abs, 11'd0}),
		.den       (den_abs),
		.side      (div1_side_i),
		.out_valid (div1_vld),
		.quot      (q1),
		.side_out  (div1_side_o)
	);

	// Stage 3: b5 = x1 + x2.
	logic signed [27:0] x2_c, b5_c, b5_s3;
	logic               err_s3;
	logic [18:0]        up_s3;

	assign x2_c = div1_side_o.neg ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
	assign b5_c = x2_c + div1_side_o.x1;

	always_ff @(posedge clk) begin
		if (en) begin
			b5_s3  <= b5_c;
			err_s3 <= div1_side_o.dz;
			up_s3  <= div1_side_o.up;
		end
	end

	// Stage 4: b6, and the rounded and saturated temperature.
	logic signed [27:0] b6_c, t_round;
	logic signed [23:0] t_div;
	logic signed [15:0] temp_c;
	logic signed [27:0] b6_s4;
	logic signed [15:0] temp_s4;
	logic               err_s4;
	logic [18:0]        up_s4;

	assign b6_c    = b5_s3 - 28'(bpc_pkg::T_OFFSET);
	assign t_round = b5_s3 + 28'sd8;
	assign t_div   = t_round[27:4];

	always_comb begin
		if (t_div > 24'(bpc_pkg::TEMP_MAX)) begin
			temp_c = 16'(bpc_pkg::TEMP_MAX);
		end else if (t_div < 24'(bpc_pkg::TEMP_MIN)) begin
			temp_c = 16'(bpc_pkg::TEMP_MIN);
		end else begin
			temp_c = t_div[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b6_s4   <= b6_c;
			temp_s4 <= temp_c;
			err_s4  <= err_s3;
			up_s4   <= up_s3;
		end
	end

	// Stage 5: b6 squared, ac2 * b6 and ac3 * b6, each wrapped to 32 bits.
	logic signed [55:0] sq_full;
	logic signed [43:0] a2_full, a3_full;
	logic [31:0]        sqw_s5, a2_s5, a3_s5;
	logic signed [15:0] temp_s5;
	logic               err_s5;
	logic [18:0]        up_s5;

	assign sq_full = b6_s4 * b6_s4;
	assign a2_full = ac2 * b6_s4;
	assign a3_full = ac3 * b6_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sqw_s5  <= sq_full[31:0];
			a2_s5   <= a2_full[31:0];
			a3_s5   <= a3_full[31:0];
			temp_s5 <= temp_s4;
			err_s5  <= err_s4;
			up_s5   <= up_s4;
		end
	end

	// Stage 6: b2 * sq and b1 * sq.
	logic signed [19:0] sq_c;
	logic signed [35:0] b2_full, b1_full;
	logic [31:0]        b2sq_s6, b1sq_s6;
	logic signed [20:0] xa2_s6;
	logic signed [18:0] xb1_s6;
	logic signed [15:0] temp_s6;
	logic               err_s6;
	logic [18:0]        up_s6;

	assign sq_c    = sqw_s5[31:12];
	assign b2_full = b2 * sq_c;
	assign b1_full = b1 * sq_c;

	always_ff @(posedge clk) begin
		if (en) begin
			b2sq_s6 <= b2_full[31:0];
			b1sq_s6 <= b1_full[31:0];
			xa2_s6  <= a2_s5[31:11];
			xb1_s6  <= a3_s5[31:13];
			temp_s6 <= temp_s5;
			err_s6  <= err_s5;
			up_s6   <= up_s5;
		end
	end

	// Stage 7: the shifted b3 term and the b4 x3 term.
	logic signed [20:0] x1a;
	logic signed [31:0] x3a, t_c, x3b_sum, x3b_c;
	logic signed [15:0] x2b;
	logic [31:0]        t_s7;
	logic signed [31:0] x3b_s7;
	logic signed [15:0] temp_s7;
	logic               err_s7;
	logic [18:0]        up_s7;

	assign x1a     = b2sq_s6[31:11];
	assign x3a     = x1a + xa2_s6;
	assign t_c     = {{14{ac1[15]}}, ac1, 2'b00} + x3a;
	assign x2b     = b1sq_s6[31:16];
	assign x3b_sum = xb1_s6 + x2b + 32'sd2;
	assign x3b_c   = x3b_sum >>> 2;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s7    <= t_c << oss_q;
			x3b_s7  <= x3b_c;
			temp_s7 <= temp_s6;
			err_s7  <= err_s6;
			up_s7   <= up_s6;
		end
	end

	// Stage 8: b3 with division toward zero, and b4.
	logic signed [31:0] v8, b3_c;
	logic [31:0]        u8;
	logic [47:0]        b4_full;
	logic signed [31:0] b3_s8;
	logic [16:0]        b4_s8;
	logic signed [15:0] temp_s8;
	logic               err_s8;
	logic [18:0]        up_s8;

	assign v8      = $signed(t_s7) + 32'sd2;
	assign b3_c    = v8[31] ? ((v8 + 32'sd3) >>> 2) : (v8 >>> 2);
	assign u8      = x3b_s7 + 32'(bpc_pkg::B4_BIAS);
	assign b4_full = ac4 * u8;

	always_ff @(posedge clk) begin
		if (en) begin
			b3_s8   <= b3_c;
			b4_s8   <= b4_full[31:15];
			temp_s8 <= temp_s7;
			err_s8  <= err_s7;
			up_s8   <= up_s7;
		end
	end

	// Stage 9: b7 = (up - b3) * (50000 >> oss).
	logic [31:0] d9;
	logic [15:0] scale;
	logic [47:0] b7_full;
	logic [31:0] b7_s9;
	logic [16:0] b4_s9;
	logic signed [15:0] temp_s9;
	logic               err_s9;

	assign d9      = {13'd0, up_s8} - b3_s8;
	assign scale   = 16'(bpc_pkg::P_SCALE >> oss_q);
	assign b7_full = d9 * scale;

	always_ff @(posedge clk) begin
		if (en) begin
			b7_s9   <= b7_full[31:0];
			b4_s9   <= b4_s8;
			temp_s9 <= temp_s8;
			err_s9  <= err_s8 || (b4_s8 == '0);
		end
	end

	// Pressure division: b7 * 2 / b4, or (b7 / b4) * 2 when b7 has its top bit set.
	bpc_pkg::div2_side_t            div2_side_i, div2_side_o;
	logic [bpc_pkg::DIV2_NUM_W-1:0] num2, q2;

	assign num2 = b7_s9[31] ? b7_s9 : {b7_s9[30:0], 1'b0};

	always_comb begin
		div2_side_i.err  = err_s9;
		div2_side_i.big  = b7_s9[31];
		div2_side_i.temp = temp_s9;
	end

	bpc_div_pipe #(
		.NUM_W  (bpc_pkg::DIV2_NUM_W),
		.DEN_W  (bpc_pkg::DIV2_DEN_W),
		.SIDE_W ($bits(bpc_pkg::div2_side_t))
	) u_div_press (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s9),
		.num       (num2),
		.den       (b4_s9),
		.side      (div2_side_i),
		.out_valid (div2_vld),
		.quot      (q2),
		.side_out  (div2_side_o)
	);

	// Stage 10: p.
	logic signed [31:0] p_s10;
	logic signed [15:0] temp_s10;
	logic               err_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s10    <= div2_side_o.big ? {q2[30:0], 1'b0} : q2;
			temp_s10 <= div2_side_o.temp;
			err_s10  <= div2_side_o.err;
		end
	end

	// Stage 11: (p >> 8) squared and -7357 * p.
	logic signed [23:0] ps;
	logic signed [47:0] pp_full;
	logic signed [45:0] m2_full;
	logic signed [31:0] pp_s11, m2_s11, p_s11;
	logic signed [15:0] temp_s11;
	logic               err_s11;

	assign ps      = p_s10[31:8];
	assign pp_full = ps * ps;
	assign m2_full = p_s10 * $signed(14'(bpc_pkg::C_X2));

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s11   <= pp_full[31:0];
			m2_s11   <= m2_full[31:0];
			p_s11    <= p_s10;
			temp_s11 <= temp_s10;
			err_s11  <= err_s10;
		end
	end

	// Stage 12: x1 * 3038 and the shifted x2.
	logic signed [44:0] x1_full;
	logic signed [15:0] x1p_s12, x2p_s12;
	logic signed [31:0] p_s12;
	logic signed [15:0] temp_s12;
	logic               err_s12;

	assign x1_full = pp_s11 * $signed(13'(bpc_pkg::C_X1));

	always_ff @(posedge clk) begin
		if (en) begin
			x1p_s12  <= x1_full[31:16];
			x2p_s12  <= m2_s11[31:16];
			p_s12    <= p_s11;
			temp_s12 <= temp_s11;
			err_s12  <= err_s11;
		end
	end

	// Stage 13: final pressure, saturation and the zero-divisor override.
	logic signed [17:0] psum;
	logic signed [13:0] pcorr;
	logic signed [31:0] press_c;
	logic [17:0]        press_sat;
	logic signed [15:0] temp_s13;
	logic [17:0]        press_s13;
	logic               err_s13;

	assign psum    = x1p_s12 + x2p_s12 + 18'(bpc_pkg::C_SUM);
	assign pcorr   = psum[17:4];
	assign press_c = p_s12 + pcorr;

	always_comb begin
		if (press_c < 32'sd0) begin
			press_sat = '0;
		end else if (press_c > 32'(bpc_pkg::PRESS_MAX)) begin
			press_sat = 18'(bpc_pkg::PRESS_MAX);
		end else begin
			press_sat = press_c[17:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			temp_s13  <= err_s12 ? '0 : temp_s12;
			press_s13 <= err_s12 ? '0 : press_sat;
			err_s13   <= err_s12;
		end
	end

	assign result.valid       = v_s13;
	assign result.temperature = temp_s13;
	assign result.pressure    = press_s13;
	assign result.math_error  = err_s13;

	`BPC_ASSERT_IMP(a_err_zero, result.valid && result.math_error, result.temperature == '0 && result.pressure == '0)
	`BPC_ASSERT_IMP(a_stall_blocks, result.valid && !result.ready, !sample.ready)
	`BPC_ASSERT_NXT(a_tail_advance, en && v_s12, result.valid)

endmodule

### verif/tb_baro_pressure_temp_compensation_core.sv
// Self-checking testbench for the barometric temperature and pressure compensation core.
module tb_baro_pressure_temp_compensation_core;
	timeunit 1ns;
	timeprecision 1ps;

	// Expected compensated reading for one accepted item.
	typedef struct {
		logic signed [bpc_pkg::TEMP_W-1:0] temperature;
		logic [bpc_pkg::PRESS_W-1:0]       pressure;
		logic                              math_error;
	} reading_t;

	// Holds a copy of the calibration and the readings still owed by the core.
	class compensation_scoreboard;
		logic [1:0]  oss;
		logic [63:0] cal_a;
		logic [63:0] cal_b;
		logic [31:0] cal_c;
		reading_t    pending[$];
		int          failures;
		int          checked;
		int          error_items;

		function new();
			oss = 2'd3;
			cal_a = '0;
			cal_b = '0;
			cal_c = '0;
			failures = 0;
			checked = 0;
			error_items = 0;
		endfunction

		function longint w32(longint v);
			return longint'(int'(v));
		endfunction

		function void set_reg(logic [1:0] idx, logic [63:0] data);
			case (idx)
				bpc_pkg::REG_OVERSAMPLING: oss = data[1:0];
				bpc_pkg::REG_CAL_WORD_A: cal_a = data;
				bpc_pkg::REG_CAL_WORD_B: cal_b = data;
				bpc_pkg::REG_CAL_WORD_C: cal_c = data[31:0];
				default: ;
			endcase
		endfunction

		// Works out the compensated reading for an accepted raw pair.
		function void note_sample(logic [15:0] raw_t, logic [18:0] raw_p);
			longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
			longint x1, x2, x3, b3, b5, b6, t, p, temp, press, den, sq;
			bit [31:0] tu, b4, b7, pu, diff;
			bit [63:0] prod;
			reading_t r;
			ac1 = longint'(shortint'(cal_a[15:0]));
			ac2 = longint'(shortint'(cal_a[31:16]));
			ac3 = longint'(shortint'(cal_a[47:32]));
			ac4 = longint'(cal_a[63:48]);
			ac5 = longint'(cal_b[15:0]);
			ac6 = longint'(cal_b[31:16]);
			b1 = longint'(shortint'(cal_b[47:32]));
			b2 = longint'(shortint'(cal_b[63:48]));
			mc = longint'(shortint'(cal_c[15:0]));
			md = longint'(shortint'(cal_c[31:16]));
			r.temperature = '0;
			r.pressure = '0;
			r.math_error = 1'b1;
			// Temperature part.
			x1 = w32(w32(longint'(raw_t) - ac6) * ac5) >>> 15;
			den = w32(x1 + md);
			if (den != 0) begin
				x2 = w32((mc * 2048) / den);
				b5 = w32(x1 + x2);
				temp = w32(b5 + 8) >>> 4;
				// Pressure part.
				b6 = w32(b5 - bpc_pkg::T_OFFSET);
				sq = w32(b6 * b6) >>> 12;
				x1 = w32(b2 * sq) >>> 11;
				x2 = w32(ac2 * b6) >>> 11;
				x3 = w32(x1 + x2);
				t = w32(ac1 * 4 + x3);
				tu = t[31:0];
				tu = tu << oss;
				t = longint'(int'(tu));
				b3 = w32(t + 2) / 4;
				x1 = w32(ac3 * b6) >>> 13;
				x2 = w32(b1 * sq) >>> 16;
				x3 = w32(w32(x1 + x2) + 2) >>> 2;
				prod = 64'(ac4) * 64'((x3 + bpc_pkg::B4_BIAS) & 64'hFFFF_FFFF);
				b4 = prod[31:0] >> 15;
				diff = 32'(raw_p) - b3[31:0];
				prod = 64'(diff) * 64'(bpc_pkg::P_SCALE >> oss);
				b7 = prod[31:0];
				if (b4 != 0) begin
					if (b7 < 32'h8000_0000)
						pu = (b7 * 2) / b4;
					else
						pu = (b7 / b4) * 2;
					p = longint'(int'(pu));
					x1 = w32((p >>> 8) * (p >>> 8));
					x1 = w32(x1 * bpc_pkg::C_X1) >>> 16;
					x2 = w32(bpc_pkg::C_X2 * p) >>> 16;
					press = w32(p + (w32(x1 + x2 + bpc_pkg::C_SUM) >>> 4));
					if (temp > bpc_pkg::TEMP_MAX) temp = bpc_pkg::TEMP_MAX;
					if (temp < bpc_pkg::TEMP_MIN) temp = bpc_pkg::TEMP_MIN;
					if (press < 0) press = 0;
					if (press > bpc_pkg::PRESS_MAX) press = bpc_pkg::PRESS_MAX;
					r.temperature = temp[15:0];
					r.pressure = press[17:0];
					r.math_error = 1'b0;
				end
			end
			pending.push_back(r);
		endfunction

		// Compares one delivered reading with the oldest expectation.
		function void check_result(logic signed [15:0] temp, logic [17:0] press, logic err);
			reading_t r;
			if (pending.size() == 0) begin
				$error("unexpected result: temperature %0d pressure %0d math_error %0b",
					temp, press, err);
				failures++;
				return;
			end
			r = pending.pop_front();
			checked++;
			if (err) error_items++;
			if (temp !== r.temperature) begin
				$error("temperature: expected %0d, got %0d", r.temperature, temp);
				failures++;
			end
			if (press !== r.pressure) begin
				$error("pressure: expected %0d, got %0d", r.pressure, press);
				failures++;
			end
			if (err !== r.math_error) begin
				$error("math_error: expected %0b, got %0b", r.math_error, err);
				failures++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [63:0] wr_data;
	longint      cycles;
	int          delivered;
	bit          hold_off;
	compensation_scoreboard sb;

	bpc_sample_if sample ();
	bpc_result_if result ();

	baro_pressure_temp_compensation_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample),
		.result   (result),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Clock generation.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Run limit.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 600000) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Result receiver: random stalls, plus one long hold-off that backs the pipeline up
	// until the input stalls.
	initial begin
		int stall;
		result.ready <= 1'b0;
		delivered = 0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				stall = 1500;
				hold_off = 1'b0;
			end else begin
				stall = $urandom_range(0, 12);
				if ($urandom_range(0, 3) == 0) stall = 0;
			end
			if (stall > 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
			delivered++;
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready)
			sb.check_result(result.temperature, result.pressure, result.math_error);
	end

	// Drives one register write; the caller drops the write enable afterwards.
	task automatic write_reg(logic [1:0] idx, logic [63:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	// Offers one item and returns once it is accepted; valid stays high afterwards.
	task automatic send_sample(logic [15:0] raw_t, logic [18:0] raw_p, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 12);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			sample.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.raw_temperature <= raw_t;
		sample.raw_pressure <= raw_p;
		do @(posedge clk); while (!sample.ready);
		sb.note_sample(raw_t, raw_p);
	endtask

	// Lets the pipeline empty before touching the registers.
	task automatic drain();
		sample.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic load_cal(logic [1:0] oss, logic [63:0] a, logic [63:0] b, logic [31:0] c);
		drain();
		write_reg(bpc_pkg::REG_OVERSAMPLING, 64'(oss));
		write_reg(bpc_pkg::REG_CAL_WORD_A, a);
		write_reg(bpc_pkg::REG_CAL_WORD_B, b);
		write_reg(bpc_pkg::REG_CAL_WORD_C, 64'(c));
		wr_en <= 1'b0;
	endtask

	// Typical sensor calibration with small random perturbation, or a fully random word when wide is set.
	function automatic logic [63:0] jitter(logic [63:0] w, bit wide);
		logic [63:0] r;
		int k;
		r = w;
		for (k = 0; k < 4; k++)
			r[16*k +: 16] = r[16*k +: 16] + 16'($signed($urandom_range(0, 64)) - 32);
		return wide ? {$urandom, $urandom} : r;
	endfunction

	task automatic random_items(int n);
		int k;
		bit burst;
		for (k = 0; k < n; k++) begin
			burst = ($urandom_range(0, 9) < 2);
			if ($urandom_range(0, 2) != 0)
				send_sample(16'($urandom_range(20000, 36000)),
					19'($urandom_range(10000, 60000) << sb.oss), burst);
			else
				send_sample(16'($urandom), 19'($urandom), burst);
		end
	endtask

	localparam logic [63:0] CAL_A_TYP = {16'd32741, 16'hC7D1, 16'hFFB8, 16'd408};
	localparam logic [63:0] CAL_B_TYP = {16'd4, 16'd6190, 16'd23153, 16'd32757};
	localparam logic [31:0] CAL_C_TYP = {16'd2868, 16'hDDF9};

	initial begin
		int ph;
		logic [63:0] a, b;
		logic [31:0] c;
		sb = new();
		hold_off = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		sample.valid = 1'b0;
		sample.raw_temperature = '0;
		sample.raw_pressure = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset calibration: the temperature divisor is zero.
		send_sample(16'h0000, 19'h00000, 1'b0);
		send_sample(16'hFFFF, 19'h7FFFF, 1'b1);

		// Typical calibration across every oversampling setting, extreme readings.
		for (ph = 0; ph < 4; ph++) begin
			load_cal(2'(ph), CAL_A_TYP, CAL_B_TYP, CAL_C_TYP);
			send_sample(16'd27898, 19'(23843 << ph), 1'b0);
			send_sample(16'h0000, 19'h00000, 1'b0);
			send_sample(16'hFFFF, 19'h7FFFF, 1'b1);
			send_sample(16'h5555, 19'h2AAAA, 1'b0);
		end
		// Zero pressure divisor: ac4 cleared.
		load_cal(2'd1, {16'd0, CAL_A_TYP[47:0]}, CAL_B_TYP, CAL_C_TYP);
		send_sample(16'd27898, 19'd47686, 1'b0);
		// Temperature divisor cancelled: no ac5 slope and md zero.
		load_cal(2'd2, CAL_A_TYP, {CAL_B_TYP[63:16], 16'd0}, {16'd0, CAL_C_TYP[15:0]});
		send_sample(16'd30000, 19'd90000, 1'b0);
		// All-ones calibration words, then zero calibration words apart from md = 1.
		load_cal(2'd3, '1, '1, '1);
		send_sample(16'hFFFF, 19'h7FFFF, 1'b0);
		send_sample(16'h0000, 19'h00000, 1'b0);
		load_cal(2'd0, '0, '0, 32'h0001_0000);
		send_sample(16'hAAAA, 19'h55555, 1'b0);

		// Random part: mostly perturbed typical calibration, some fully random.
		for (ph = 0; ph < 12; ph++) begin
			a = jitter(CAL_A_TYP, ph % 4 == 3);
			b = jitter(CAL_B_TYP, ph % 4 == 3);
			c = (ph % 4 == 3) ? $urandom : 32'(jitter({32'd0, CAL_C_TYP}, 1'b0));
			load_cal(2'($urandom_range(0, 3)), a, b, c);
			// The receiver holds off early in this batch so the pipeline fills.
			if (ph == 1) hold_off = 1'b1;
			random_items(100);
		end
		drain();

		$display("Covered %0d results, %0d with a zero divisor, over the reset state and",
			sb.checked, sb.error_items);
		$display("20 loaded calibrations, including one long output hold-off.");
		if (sb.failures == 0 && sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
